>>> src/adaptive_binary_range_encoder_macros.svh
// Assertion macros used by the top-level encoder source.
`ifndef ADAPTIVE_BINARY_RANGE_ENCODER_MACROS_SVH
`define ADAPTIVE_BINARY_RANGE_ENCODER_MACROS_SVH

`ifndef ASSERT_OFF

`define ABRE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ABRE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ABRE_ASSERT(lbl, clk, rst, prop, msg)

`define ABRE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> src/abre_pkg.sv
`timescale 1ns / 1ps

package abre_pkg;

   localparam int CTX_FIELD_W = 19;
   localparam int RANGE_W     = 32;
   localparam int PROB_W      = 12;
   localparam int PROB_SHIFT  = 12;
   localparam int ADAPT_SHIFT = 5;
   localparam int EPOCH_W     = 8;
   localparam int MAX_EMIT    = 8;
   localparam int FLUSH_BYTES = 4;
   localparam int EMIT_CNT_W  = $clog2(MAX_EMIT + 1);

   localparam logic [PROB_W-1:0]  PROB_INIT = 12'd2048;
   localparam logic [PROB_W:0]    PROB_ONE  = 13'd4096;
   localparam logic [RANGE_W-1:0] RANGE_INIT = 32'hFFFF_FFFF;

   typedef struct packed {
      logic                   mode;
      logic                   bit_value;
      logic [CTX_FIELD_W-1:0] context_index;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic [PROB_W-1:0]  prob;
   } prob_word_type;

   typedef struct packed {
      logic [RANGE_W-1:0] bound;
      prob_word_type      word;
   } model_upd_type;

endpackage

>>> src/abre_prob_mem.sv
`timescale 1ns / 1ps

module abre_prob_mem #(
   parameter int ADDR_W = 19
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  abre_pkg::prob_word_type wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output abre_pkg::prob_word_type rd_data
);

   abre_pkg::prob_word_type mem [2**ADDR_W];
   abre_pkg::prob_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/abre_model_update.sv
`timescale 1ns / 1ps

module abre_model_update (
   input  abre_pkg::prob_word_type              rd_word,
   input  logic [abre_pkg::EPOCH_W-1:0]         epoch,
   input  logic [abre_pkg::RANGE_W-abre_pkg::PROB_SHIFT-1:0] range_hi,
   input  logic                                 bit_value,
   output abre_pkg::model_upd_type              upd
);

   logic [abre_pkg::PROB_W-1:0] prob;
   logic [abre_pkg::PROB_W-1:0] delta_up;
   logic [abre_pkg::PROB_W-1:0] delta_dn;
   logic [abre_pkg::PROB_W:0]   gap;

   // An entry written before the last clear of the table reads as the initial value.
   assign prob = (rd_word.tag == epoch) ? rd_word.prob : abre_pkg::PROB_INIT;

   assign gap      = abre_pkg::PROB_ONE - {1'b0, prob};
   assign delta_up = abre_pkg::PROB_W'(gap >> abre_pkg::ADAPT_SHIFT);
   assign delta_dn = prob >> abre_pkg::ADAPT_SHIFT;

   always_comb begin
      upd.bound    = abre_pkg::RANGE_W'(range_hi) * abre_pkg::RANGE_W'(prob);
      upd.word.tag = epoch;
      if (bit_value) begin
         upd.word.prob = prob + delta_up;
      end else begin
         upd.word.prob = prob - delta_dn;
      end
   end

endmodule

>>> src/adaptive_binary_range_encoder.sv
`timescale 1ns / 1ps

// Adaptive binary range encoder with a carryless byte output. Each request transfer either
// codes one decision under the probability selected by its context index or, in finish
// mode, emits the four bytes of low and restarts the coder and the whole probability table.
// An encode runs through the memory read, the multiply and write-back, the interval update and
// the renormalisation steps, which produce up to eight bytes, before the next request transfer
// is accepted. The table lives in a single-port-read, single-port-write memory whose entries
// carry an eight-bit generation tag, so a finish clears it at once; the request side is held
// off after reset, and again after every 255th finish, while all 2**CONTEXT_BITS entries of
// the memory are swept. Result transfers leave through an output register, and back-pressure
// on them stalls only the byte emission.

`include "adaptive_binary_range_encoder_macros.svh"

module adaptive_binary_range_encoder #(
   parameter int CONTEXT_BITS = 19
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  abre_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output abre_pkg::rsp_type rsp_payload
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_APPLY,
      ST_RENORM,
      ST_FLUSH,
      ST_CLEAR
   } state_type;

   localparam int RW = abre_pkg::RANGE_W;
   localparam int CW = abre_pkg::EMIT_CNT_W;
   localparam int EW = abre_pkg::EPOCH_W;

   state_type                state_ff, state_in;
   logic [RW-1:0]            low_ff, low_in;
   logic [RW-1:0]            range_ff, range_in;
   logic [RW-1:0]            bound_ff, bound_in;
   logic [EW-1:0]            epoch_ff, epoch_in;
   logic [CONTEXT_BITS-1:0]  clr_addr_ff, clr_addr_in;
   logic [CONTEXT_BITS-1:0]  idx_ff, idx_in;
   logic                     bit_ff, bit_in;
   logic [CW-1:0]            cnt_ff, cnt_in;
   logic [7:0]               hold_ff, hold_in;
   logic                     hold_v_ff, hold_v_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   abre_pkg::rsp_type        rsp_ff, rsp_in;

   logic [CONTEXT_BITS-1:0]  req_idx;
   logic                     req_fire;
   logic                     out_free;
   logic                     mem_wr_en;
   logic [CONTEXT_BITS-1:0]  mem_wr_addr;
   abre_pkg::prob_word_type  mem_wr_data;
   abre_pkg::prob_word_type  mem_rd_data;
   abre_pkg::model_upd_type  upd;

   logic [RW-1:0]            top_sum;
   logic [RW-1:0]            top_diff;
   logic                     agree;
   logic                     narrow;
   logic [RW-1:0]            range_adj;
   logic                     emit_go;
   logic [EW-1:0]            epoch_next;

   if (CONTEXT_BITS <= abre_pkg::CTX_FIELD_W) begin : g_idx_cut
      assign req_idx = req_payload.context_index[CONTEXT_BITS-1:0];
   end else begin : g_idx_ext
      assign req_idx = {{(CONTEXT_BITS - abre_pkg::CTX_FIELD_W){1'b0}},
                        req_payload.context_index};
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   abre_prob_mem #(
      .ADDR_W (CONTEXT_BITS)
   ) u_prob_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_idx),
      .rd_data (mem_rd_data)
   );

   abre_model_update u_model_update (
      .rd_word   (mem_rd_data),
      .epoch     (epoch_ff),
      .range_hi  (range_ff[RW-1:abre_pkg::PROB_SHIFT]),
      .bit_value (bit_ff),
      .upd       (upd)
   );

   always_comb begin
      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff;
      mem_wr_data = upd.word;
      if (state_ff == ST_LOOKUP) begin
         mem_wr_en = 1'b1;
      end else if (state_ff == ST_CLEAR) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end
   end

   assign top_sum   = low_ff + range_ff;
   assign top_diff  = low_ff ^ top_sum;
   assign agree     = (top_diff[RW-1:RW-8] == 8'd0);
   assign narrow    = (range_ff[RW-1:16] == 16'd0);
   assign range_adj = agree ? range_ff : {16'd0, 16'd0 - low_ff[15:0]};
   assign emit_go   = (agree || narrow) && (cnt_ff < CW'(abre_pkg::MAX_EMIT));
   assign epoch_next = epoch_ff + EW'(1);

   always_comb begin
      state_in     = state_ff;
      low_in       = low_ff;
      range_in     = range_ff;
      bound_in     = bound_ff;
      epoch_in     = epoch_ff;
      clr_addr_in  = clr_addr_ff;
      idx_in       = idx_ff;
      bit_in       = bit_ff;
      cnt_in       = cnt_ff;
      hold_in      = hold_ff;
      hold_v_in    = hold_v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               idx_in = req_idx;
               bit_in = req_payload.bit_value;
               cnt_in = '0;
               if (req_payload.mode) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_LOOKUP;
               end
            end
         end
         ST_LOOKUP: begin
            bound_in = upd.bound;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (bit_ff) begin
               range_in = bound_ff;
            end else begin
               low_in   = low_ff + bound_ff;
               range_in = range_ff - bound_ff;
            end
            cnt_in    = '0;
            hold_v_in = 1'b0;
            state_in  = ST_RENORM;
         end
         ST_RENORM: begin
            if (emit_go) begin
               if (!hold_v_ff || out_free) begin
                  if (hold_v_ff) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.out_byte      = hold_ff;
                     rsp_in.last_of_run   = 1'b0;
                  end
                  hold_in   = low_ff[RW-1:RW-8];
                  hold_v_in = 1'b1;
                  low_in    = low_ff << 8;
                  range_in  = range_adj << 8;
                  cnt_in    = cnt_ff + CW'(1);
               end
            end else if (hold_v_ff) begin
               if (out_free) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.out_byte    = hold_ff;
                  rsp_in.last_of_run = 1'b1;
                  hold_v_in          = 1'b0;
                  state_in           = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.out_byte    = low_ff[RW-1:RW-8];
               rsp_in.last_of_run = (cnt_ff == CW'(abre_pkg::FLUSH_BYTES - 1));
               low_in             = low_ff << 8;
               cnt_in             = cnt_ff + CW'(1);
               if (cnt_ff == CW'(abre_pkg::FLUSH_BYTES - 1)) begin
                  low_in   = '0;
                  range_in = abre_pkg::RANGE_INIT;
                  if (epoch_next == '0) begin
                     epoch_in    = EW'(1);
                     clr_addr_in = '0;
                     state_in    = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_next;
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + CONTEXT_BITS'(1);
            if (clr_addr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         low_ff       <= '0;
         range_ff     <= abre_pkg::RANGE_INIT;
         epoch_ff     <= EW'(1);
         clr_addr_ff  <= '0;
         cnt_ff       <= '0;
         hold_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         range_ff     <= range_in;
         epoch_ff     <= epoch_in;
         clr_addr_ff  <= clr_addr_in;
         cnt_ff       <= cnt_in;
         hold_v_ff    <= hold_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bound_ff <= bound_in;
      idx_ff   <= idx_in;
      bit_ff   <= bit_in;
      hold_ff  <= hold_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ABRE_ASSERT(a_no_rd_wr_overlap, clock, reset, !(req_fire && mem_wr_en), "memory read and write in the same cycle")
   `ABRE_ASSERT(a_hold_in_renorm, clock, reset, hold_v_ff |-> (state_ff == ST_RENORM), "held byte outside renormalisation")
   `ABRE_ASSERT(a_emit_cap, clock, reset, cnt_ff <= CW'(abre_pkg::MAX_EMIT), "emission count beyond its cap")
   `ABRE_ASSERT(a_epoch_live, clock, reset, (state_ff != ST_CLEAR) |-> (epoch_ff != '0), "generation tag zero outside a clear")
   `ABRE_ASSERT(a_write_after_lookup, clock, reset, (state_ff == ST_LOOKUP) |=> (state_ff == ST_APPLY), "interval update did not follow the table write")

endmodule

>>> bench/adaptive_binary_range_encoder_tb.sv
`timescale 1ns / 1ps

class byte_stream_scoreboard;
   localparam logic        MODE_FINISH = 1'b1;
   localparam logic [31:0] TOP_LIMIT   = 32'h0100_0000;
   localparam logic [31:0] BOT_LIMIT   = 32'h0001_0000;
   localparam int unsigned PROB_ONE_V  = 4096;

   logic [31:0]        low;
   logic [31:0]        span;
   logic [11:0]        prob [int unsigned];
   int unsigned        ctx_mask;
   abre_pkg::rsp_type  pending_bytes [$];
   int unsigned        errors;
   int unsigned        checked;
   int unsigned        issued;
   int unsigned        finishes;
   int unsigned        total_expected;

   function new(int ctx_bits);
      ctx_mask       = (1 << ctx_bits) - 1;
      errors         = 0;
      checked        = 0;
      issued         = 0;
      finishes       = 0;
      total_expected = 0;
      restart();
   endfunction

   function void restart();
      low  = 32'd0;
      span = abre_pkg::RANGE_INIT;
      prob.delete();
   endfunction

   function void report(string line);
      errors++;
      if (errors <= 10) begin
         $display("%s", line);
      end
   endfunction

   function int unsigned pending();
      return pending_bytes.size();
   endfunction

   function void note_request(abre_pkg::req_type r);
      abre_pkg::rsp_type burst [$];
      abre_pkg::rsp_type one;
      logic [31:0]       bound;
      int unsigned       p;
      int unsigned       idx;
      issued++;
      if (r.mode == MODE_FINISH) begin
         finishes++;
         for (int i = 0; i < abre_pkg::FLUSH_BYTES; i++) begin
            one.out_byte    = low[31:24];
            one.last_of_run = (i == abre_pkg::FLUSH_BYTES - 1);
            burst.push_back(one);
            low = low << 8;
         end
         restart();
      end else begin
         idx   = r.context_index & ctx_mask;
         p     = prob.exists(idx) ? prob[idx] : abre_pkg::PROB_INIT;
         bound = (span >> abre_pkg::PROB_SHIFT) * p;
         if (r.bit_value) begin
            span = bound;
            p    = p + ((PROB_ONE_V - p) >> abre_pkg::ADAPT_SHIFT);
         end else begin
            low  = low + bound;
            span = span - bound;
            p    = p - (p >> abre_pkg::ADAPT_SHIFT);
         end
         prob[idx] = 12'(p);
         while (burst.size() < abre_pkg::MAX_EMIT) begin
            if ((low ^ (low + span)) >= TOP_LIMIT) begin
               if (span >= BOT_LIMIT) begin
                  break;
               end
               span = (32'd0 - low) & (BOT_LIMIT - 32'd1);
            end
            one.out_byte    = low[31:24];
            one.last_of_run = 1'b0;
            burst.push_back(one);
            low  = low << 8;
            span = span << 8;
         end
         if (burst.size() > 0) begin
            burst[burst.size() - 1].last_of_run = 1'b1;
         end
      end
      foreach (burst[i]) begin
         pending_bytes.push_back(burst[i]);
      end
      total_expected += burst.size();
   endfunction

   function void check_response(abre_pkg::rsp_type got);
      abre_pkg::rsp_type want;
      if (pending_bytes.size() == 0) begin
         report($sformatf("unexpected transfer: byte %02h last %0d",
                          got.out_byte, got.last_of_run));
      end else begin
         want = pending_bytes.pop_front();
         checked++;
         if (got.out_byte !== want.out_byte) begin
            report($sformatf("out_byte mismatch: expected %02h, got %02h",
                             want.out_byte, got.out_byte));
         end
         if (got.last_of_run !== want.last_of_run) begin
            report($sformatf("last_of_run mismatch on byte %02h: expected %0d, got %0d",
                             want.out_byte, want.last_of_run, got.last_of_run));
         end
      end
   endfunction
endclass

module adaptive_binary_range_encoder_tb;

   localparam int          CTX_BITS     = 19;
   localparam int unsigned STALL_LIMIT  = 4 * (1 << CTX_BITS) + 20000;
   localparam int          DRAIN_CYCLES = 64;
   localparam int          RANDOM_ITEMS = 89;
   localparam int          POOL_SIZE    = 6;
   localparam logic        MODE_ENCODE  = 1'b0;
   localparam logic        MODE_FINISH  = 1'b1;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   abre_pkg::req_type req_payload;
   logic              rsp_valid;
   logic              rsp_ready;
   abre_pkg::rsp_type rsp_payload;

   byte_stream_scoreboard board;
   bit                    calm;
   int unsigned           quiet_cycles;

   adaptive_binary_range_encoder #(
      .CONTEXT_BITS(CTX_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   task automatic drive_request(input abre_pkg::req_type item);
      int unsigned gap;
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= STALL_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles + 1);
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         board.check_response(rsp_payload);
      end
   end

   initial begin : rsp_side
      int unsigned hold;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         rsp_ready <= 1'b1;
         repeat ($urandom_range(0, 11)) @(negedge clock);
         hold = pick_gap();
         if (hold > 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (hold - 1) @(negedge clock);
         end
      end
   end

   initial begin : stimulus
      abre_pkg::req_type directed [21];
      abre_pkg::req_type item;
      logic [18:0]       pool [POOL_SIZE];
      int unsigned       bias;
      int unsigned       r;
      int unsigned       random_count;
      abre_pkg::rsp_type left;

      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      rsp_ready    = 1'b0;
      calm         = 1'b0;
      random_count = 0;
      bias         = 50;
      board        = new(CTX_BITS);
      foreach (pool[i]) begin
         pool[i] = 19'($urandom);
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      directed = '{
         '{MODE_ENCODE, 1'b1, 19'h00000},
         '{MODE_ENCODE, 1'b0, 19'h7FFFF},
         '{MODE_ENCODE, 1'b1, 19'h55555},
         '{MODE_ENCODE, 1'b0, 19'h2AAAA},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_ENCODE, 1'b0, 19'h00005},
         '{MODE_ENCODE, 1'b0, 19'h00005},
         '{MODE_ENCODE, 1'b0, 19'h00005},
         '{MODE_ENCODE, 1'b0, 19'h00005},
         '{MODE_FINISH, 1'b1, 19'h7FFFF},
         '{MODE_FINISH, 1'b0, 19'h00000},
         '{MODE_ENCODE, 1'b0, 19'h00005},
         '{MODE_ENCODE, 1'b1, 19'h00005},
         '{MODE_FINISH, 1'b0, 19'h2AAAA}
      };
      foreach (directed[i]) begin
         drive_request(directed[i]);
      end

      while (random_count < RANDOM_ITEMS) begin
         calm = (random_count % 50) >= 35;
         r    = $urandom_range(0, 99);
         item.context_index = 19'($urandom);
         item.bit_value     = 1'($urandom);
         item.mode          = MODE_ENCODE;
         if (r < 8) begin
            item.mode = MODE_FINISH;
            foreach (pool[i]) begin
               pool[i] = 19'($urandom);
            end
         end else if (r < 88) begin
            item.context_index = pool[$urandom_range(0, POOL_SIZE - 1)];
            item.bit_value     = ($urandom_range(0, 99) < bias);
         end
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
               0: begin
                  bias = 3;
               end
               1: begin
                  bias = 97;
               end
               default: begin
                  bias = 50;
               end
            endcase
         end
         drive_request(item);
         random_count++;
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      while (board.pending() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      while (board.pending() != 0) begin
         left = board.pending_bytes.pop_front();
         board.report($sformatf("missing transfer: expected byte %02h last %0d",
                                left.out_byte, left.last_of_run));
      end

      $display("Coded %0d request transfers (%0d stream finishes) and checked %0d bytes.",
               board.issued, board.finishes, board.checked);
      $display("Mismatches and missing or surplus bytes counted: %0d.", board.errors);
      if (board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
